// ----- rtl/heq_pkg.sv -----
// Shared constants and types for the histogram equalizer.
// Used by every module of the block; depends on nothing.
package heq_pkg;

    localparam int COUNT_BITS = 24;
    localparam int LEVELS     = 256;
    localparam int LVL_W      = $clog2(LEVELS);
    localparam int TOT_W      = COUNT_BITS + 1;
    localparam int NUM_W      = TOT_W + LVL_W;
    localparam int STEP_W     = $clog2(LVL_W);

    localparam logic [TOT_W-1:0] TOTAL_MAX = TOT_W'(1) << COUNT_BITS;
    localparam logic [LVL_W-1:0] LVL_MAX   = LVL_W'(LEVELS - 1);

    localparam logic [1:0] KIND_COUNT = 2'd0;
    localparam logic [1:0] KIND_MAP   = 2'd1;
    localparam logic [1:0] KIND_CLEAR = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic pix_load;
        logic hist_clear;
        logic bin_rd_pix;
        logic bin_wr;
        logic bin_rd_idx;
        logic acc_clear;
        logic acc_add;
        logic mul;
        logic div_start;
        logic tab_wr;
        logic tab_rd;
        logic out_load;
    } heq_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic total_full;
        logic div_done;
        logic idx_last;
        logic out_free;
    } heq_stat_t;

endpackage

// ----- rtl/heq_div.sv -----
// Shift-subtract divider giving an 8-bit quotient, one bit per cycle.
// Depends on heq_pkg. The caller guarantees the quotient fits in LVL_W bits.
module heq_div (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [heq_pkg::NUM_W-1:0] num,
    input  logic [heq_pkg::TOT_W-1:0] den,
    output logic                      done,
    output logic [heq_pkg::LVL_W-1:0] quot
);
    import heq_pkg::*;

    logic [NUM_W-1:0]  rem_reg, rem_next;
    logic [TOT_W-1:0]  den_reg;
    logic [LVL_W-1:0]  quot_reg, quot_next;
    logic [STEP_W-1:0] step_reg;
    logic              busy_reg, done_reg;
    logic [NUM_W-1:0]  trial;

    assign trial = NUM_W'(den_reg) << step_reg;

    always_comb begin
        rem_next  = rem_reg;
        quot_next = quot_reg;
        if (rem_reg >= trial) begin
            rem_next            = rem_reg - trial;
            quot_next[step_reg] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && step_reg == '0) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg  <= num;
            den_reg  <= den;
            quot_reg <= '0;
            step_reg <= STEP_W'(LVL_W - 1);
        end else if (busy_reg) begin
            rem_reg  <= rem_next;
            quot_reg <= quot_next;
            step_reg <= step_reg - 1'b1;
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

// ----- rtl/heq_dp.sv -----
// Datapath: histogram memory, pixel total, cumulative sum, table memory, output word.
// Depends on heq_pkg and heq_div; driven by heq_ctrl through heq_cmd_t.
module heq_dp (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  heq_pkg::heq_cmd_t         cmd,
    output heq_pkg::heq_stat_t        stat,
    input  logic [heq_pkg::LVL_W-1:0] s_pixel,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [heq_pkg::LVL_W-1:0] m_tdata
);
    import heq_pkg::*;

    logic [TOT_W-1:0] bin_mem [LEVELS];
    logic [LVL_W-1:0] tab_mem [LEVELS];
    logic [LEVELS-1:0] bin_vld_reg;

    logic [LVL_W-1:0] pix_reg;
    logic [LVL_W-1:0] idx_reg;
    logic [TOT_W-1:0] total_reg;
    logic [TOT_W-1:0] running_reg;
    logic [NUM_W-1:0] prod_reg;
    logic [TOT_W-1:0] bin_rdata_reg;
    logic             bin_rvld_reg;
    logic [LVL_W-1:0] tab_rdata_reg;
    logic             out_vld_reg;
    logic [LVL_W-1:0] out_data_reg;
    logic [TOT_W-1:0] bin_val;
    logic [LVL_W-1:0] bin_addr;
    logic [LVL_W-1:0] quot;
    logic             div_done;

    assign bin_val  = bin_rvld_reg ? bin_rdata_reg : '0;
    assign bin_addr = cmd.bin_rd_idx ? idx_reg : s_pixel;

    heq_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.div_start),
        .num     (prod_reg),
        .den     (total_reg),
        .done    (div_done),
        .quot    (quot)
    );

    // Histogram memory with per-bin valid bits so that a clear needs no pass over the bins.
    always_ff @(posedge aclk) begin
        if (cmd.bin_rd_pix || cmd.bin_rd_idx) begin
            bin_rdata_reg <= bin_mem[bin_addr];
            bin_rvld_reg  <= bin_vld_reg[bin_addr];
        end
        if (cmd.bin_wr) begin
            bin_mem[pix_reg] <= bin_val + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bin_vld_reg <= '0;
            total_reg   <= '0;
        end else if (cmd.hist_clear) begin
            bin_vld_reg <= '0;
            total_reg   <= '0;
        end else if (cmd.bin_wr) begin
            bin_vld_reg[pix_reg] <= 1'b1;
            total_reg            <= total_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.tab_wr) begin
            tab_mem[idx_reg] <= (total_reg == '0) ? '0 : quot;
        end
        if (cmd.tab_rd) begin
            tab_rdata_reg <= tab_mem[pix_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.pix_load) begin
            pix_reg <= s_pixel;
        end
        if (cmd.acc_clear) begin
            running_reg <= '0;
            idx_reg     <= '0;
        end else begin
            if (cmd.acc_add) begin
                running_reg <= running_reg + bin_val;
            end
            if (cmd.tab_wr) begin
                idx_reg <= idx_reg + 1'b1;
            end
        end
        // 255 * running as a shift and a subtract.
        if (cmd.mul) begin
            prod_reg <= (NUM_W'(running_reg) << LVL_W) - NUM_W'(running_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_vld_reg <= 1'b1;
        end else if (m_tready) begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_data_reg <= tab_rdata_reg;
        end
    end

    assign m_tvalid        = out_vld_reg;
    assign m_tdata         = out_data_reg;
    assign stat.total_full = (total_reg >= TOTAL_MAX);
    assign stat.div_done   = div_done;
    assign stat.idx_last   = (idx_reg == LVL_MAX);
    assign stat.out_free   = !out_vld_reg || m_tready;

endmodule

// ----- rtl/heq_ctrl.sv -----
// Controller state machine: decodes input words and sequences the table build.
// Depends on heq_pkg; commands heq_dp through heq_cmd_t.
module heq_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [1:0]         s_kind,
    input  heq_pkg::heq_stat_t stat,
    output heq_pkg::heq_cmd_t  cmd
);
    import heq_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CNT_WR,
        ST_B_RD,
        ST_B_ACC,
        ST_B_MUL,
        ST_B_DIV,
        ST_B_WAIT,
        ST_MAP_RD,
        ST_MAP_OUT
    } state_t;

    state_t state_reg, state_next;
    logic   ready_reg, ready_next;
    logic   accept;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        state_next = state_reg;
        ready_next = ready_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    cmd.pix_load = 1'b1;
                    if (s_kind == KIND_COUNT) begin
                        cmd.bin_rd_pix = 1'b1;
                        ready_next     = 1'b0;
                        state_next     = ST_CNT_WR;
                    end else if (s_kind == KIND_MAP) begin
                        if (ready_reg) begin
                            state_next = ST_MAP_RD;
                        end else begin
                            cmd.acc_clear = 1'b1;
                            state_next    = ST_B_RD;
                        end
                    end else if (s_kind == KIND_CLEAR) begin
                        cmd.hist_clear = 1'b1;
                        ready_next     = 1'b0;
                    end
                end
            end
            ST_CNT_WR: begin
                cmd.bin_wr = !stat.total_full;
                state_next = ST_IDLE;
            end
            ST_B_RD: begin
                cmd.bin_rd_idx = 1'b1;
                state_next     = ST_B_ACC;
            end
            ST_B_ACC: begin
                cmd.acc_add = 1'b1;
                state_next  = ST_B_MUL;
            end
            ST_B_MUL: begin
                cmd.mul    = 1'b1;
                state_next = ST_B_DIV;
            end
            ST_B_DIV: begin
                cmd.div_start = 1'b1;
                state_next    = ST_B_WAIT;
            end
            ST_B_WAIT: begin
                if (stat.div_done) begin
                    cmd.tab_wr = 1'b1;
                    if (stat.idx_last) begin
                        ready_next = 1'b1;
                        state_next = ST_MAP_RD;
                    end else begin
                        state_next = ST_B_RD;
                    end
                end
            end
            ST_MAP_RD: begin
                cmd.tab_rd = 1'b1;
                state_next = ST_MAP_OUT;
            end
            ST_MAP_OUT: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ready_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            ready_reg <= ready_next;
        end
    end

endmodule

// ----- rtl/histogram_equalizer.sv -----
// Histogram equalizer top level. A clear word empties the histogram; a count word does a bin
// read-modify-write. A map word with a built table reads the table into the output word.
// The first map after any count or clear builds the table first, for all 256 levels, with
// the one-bit-per-cycle divider. Reset (aresetn low, synchronous) empties the
// histogram at once through per-bin valid bits and marks the table as not built.
module histogram_equalizer (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [heq_pkg::LVL_W-1:0] s_tdata,  // [7:0] pixel
    input  logic [1:0]                s_tuser,  // [1:0] kind
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [heq_pkg::LVL_W-1:0] m_tdata   // [7:0] mapped_pixel
);
    import heq_pkg::*;

    heq_cmd_t  cmd;
    heq_stat_t stat;

    heq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_kind   (s_tuser),
        .stat     (stat),
        .cmd      (cmd)
    );

    heq_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .stat     (stat),
        .s_pixel  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

// ----- rtl/heq_checker.sv -----
// Port-level checks for the histogram equalizer, bound to the top level.
// Depends on heq_pkg and histogram_equalizer.
module heq_checker (
    input logic                      aclk,
    input logic                      aresetn,
    input logic                      s_tvalid,
    input logic                      s_tready,
    input logic [heq_pkg::LVL_W-1:0] s_tdata,
    input logic [1:0]                s_tuser,
    input logic                      m_tvalid,
    input logic                      m_tready,
    input logic [heq_pkg::LVL_W-1:0] m_tdata
);
    import heq_pkg::*;

    // A stalled output word holds.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output word changed while stalled");

    a_reset_out: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

    // A result only appears after the input side has been held off.
    a_out_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> !$past(s_tready))
        else $error("result without a map word in progress");

    a_count_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser == KIND_COUNT |=> !s_tready)
        else $error("count word did not take its write cycle");

    a_clear_fast: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser == KIND_CLEAR |=> s_tready)
        else $error("clear word stalled the input");

endmodule

bind histogram_equalizer heq_checker u_heq_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ----- test/histogram_equalizer_test.sv -----
// Self-checking testbench for the histogram equalizer: directed and random count,
// map and clear words against a behavioral equalizer. Depends on heq_pkg and the RTL.
module histogram_equalizer_test;
    timeunit 1ns;
    timeprecision 1ps;
    import heq_pkg::*;

    // The one kind code the block ignores.
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [LVL_W-1:0] s_tdata = '0;
    logic [1:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [LVL_W-1:0] m_tdata;

    histogram_equalizer dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    typedef struct packed {
        logic [1:0] kind;
        logic [LVL_W-1:0] pixel;
    } pix_word_t;

    // Behavioral equalizer state.
    logic [TOT_W-1:0] hist [LEVELS];
    logic [TOT_W-1:0] hist_total;
    logic [LVL_W-1:0] eq_table [LEVELS];
    bit eq_table_built;

    pix_word_t pending_words [$];
    logic [LVL_W-1:0] expected_pixels [$];
    int mismatches = 0;
    bit hold_sender = 0;
    int long_stall = 0;
    int gap_in = 0;
    int gap_out = 0;
    int maps_sent = 0;

    function automatic int rand_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 20);
        return $urandom_range(40, 150);
    endfunction

    task automatic equalize_word(input pix_word_t w);
        logic [TOT_W+LVL_W-1:0] running;
        logic [TOT_W+LVL_W+8:0] q;
        case (w.kind)
            KIND_COUNT: begin
                eq_table_built = 0;
                if (hist_total < TOTAL_MAX) begin
                    hist[w.pixel] = hist[w.pixel] + 1'b1;
                    hist_total = hist_total + 1'b1;
                end
            end
            KIND_MAP: begin
                if (!eq_table_built) begin
                    running = '0;
                    for (int v = 0; v < LEVELS; v++) begin
                        running = running + hist[v];
                        if (hist_total == 0) eq_table[v] = '0;
                        else begin
                            q = (255 * running) / hist_total;
                            eq_table[v] = (q > 255) ? 8'd255 : q[7:0];
                        end
                    end
                    eq_table_built = 1;
                end
                expected_pixels.push_back(eq_table[w.pixel]);
            end
            KIND_CLEAR: begin
                for (int v = 0; v < LEVELS; v++) hist[v] = '0;
                hist_total = '0;
                eq_table_built = 0;
            end
            default: ;
        endcase
    endtask

    // Driver.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                equalize_word(pix_word_t'({s_tuser, s_tdata}));
            end
            if (!s_tvalid || s_tready) begin
                if (gap_in > 0) begin
                    gap_in <= gap_in - 1;
                    s_tvalid <= 1'b0;
                end else if (pending_words.size() > 0 && !hold_sender) begin
                    pix_word_t w;
                    w = pending_words.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser <= w.kind;
                    s_tdata <= w.pixel;
                    gap_in <= rand_gap();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Long receiver stall, counted down in cycles.
    always @(posedge aclk) begin
        if (long_stall > 0) begin
            long_stall <= long_stall - 1;
        end
    end

    // Monitor; the receiver holds off while a long stall is running.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_pixels.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected output word %0d", m_tdata);
                end else begin
                    logic [LVL_W-1:0] e;
                    e = expected_pixels.pop_front();
                    if (m_tdata !== e) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mapped_pixel mismatch: expected %0d got %0d", e, m_tdata);
                    end
                end
            end
            if (long_stall > 0) begin
                m_tready <= 1'b0;
            end else if (gap_out > 0) begin
                gap_out <= gap_out - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                gap_out <= rand_gap();
            end
        end
    end

    function automatic pix_word_t mk(input logic [1:0] k, input logic [7:0] p);
        mk.kind = k;
        mk.pixel = p;
    endfunction

    function automatic logic [7:0] rand_pix(input int lo, input int hi);
        return 8'($urandom_range(hi, lo));
    endfunction

    task automatic wait_drained();
        while (pending_words.size() > 0 || s_tvalid || expected_pixels.size() > 0)
            @(posedge aclk);
    endtask

    initial begin
        hist_total = '0;
        eq_table_built = 0;
        for (int v = 0; v < LEVELS; v++) begin
            hist[v] = '0;
            eq_table[v] = '0;
        end
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: empty histogram, extremes, unused kind, count after map.
        pending_words.push_back(mk(KIND_MAP, 8'd0));
        pending_words.push_back(mk(KIND_MAP, 8'd255));
        pending_words.push_back(mk(KIND_UNUSED, 8'hAA));
        pending_words.push_back(mk(KIND_COUNT, 8'd0));
        pending_words.push_back(mk(KIND_COUNT, 8'd255));
        pending_words.push_back(mk(KIND_COUNT, 8'h55));
        pending_words.push_back(mk(KIND_COUNT, 8'hAA));
        pending_words.push_back(mk(KIND_MAP, 8'd0));
        pending_words.push_back(mk(KIND_MAP, 8'h55));
        pending_words.push_back(mk(KIND_MAP, 8'd255));
        pending_words.push_back(mk(KIND_COUNT, 8'd128));
        pending_words.push_back(mk(KIND_MAP, 8'd128));
        pending_words.push_back(mk(KIND_MAP, 8'd127));
        pending_words.push_back(mk(KIND_CLEAR, 8'hFF));
        pending_words.push_back(mk(KIND_MAP, 8'd7));
        pending_words.push_back(mk(KIND_COUNT, 8'd200));
        pending_words.push_back(mk(KIND_MAP, 8'd199));
        pending_words.push_back(mk(KIND_MAP, 8'd200));
        wait_drained();

        // The sender has paused until every result is in; now a long receiver stall
        // while a burst of map words fills the block.
        hold_sender = 1;
        repeat (20) @(posedge aclk);
        hold_sender = 0;
        long_stall = 400;
        for (int i = 0; i < 30; i++) pending_words.push_back(mk(KIND_MAP, rand_pix(0, 255)));
        wait_drained();

        // Random frames: a clear in most frames, a counting pass, then a mapping pass. Map passes
        // are kept short since each table build runs the divider once for every level.
        while (maps_sent < 700) begin
            int n_count, n_map;
            if ($urandom_range(0, 9) != 0)
                pending_words.push_back(mk(KIND_CLEAR, rand_pix(0, 255)));
            n_count = $urandom_range(0, 9) == 0 ? $urandom_range(0, 3) : $urandom_range(4, 60);
            for (int i = 0; i < n_count; i++) begin
                logic [7:0] p;
                p = $urandom_range(0, 3) == 0 ? rand_pix(0, 255) : rand_pix(100, 140);
                pending_words.push_back(mk(KIND_COUNT, p));
            end
            n_map = $urandom_range(20, 60);
            for (int i = 0; i < n_map; i++) begin
                int r;
                r = $urandom_range(0, 39);
                if (r == 0) pending_words.push_back(mk(KIND_UNUSED, rand_pix(0, 255)));
                else if (r == 1) pending_words.push_back(mk(KIND_COUNT, rand_pix(0, 255)));
                else begin
                    pending_words.push_back(mk(KIND_MAP, rand_pix(0, 255)));
                    maps_sent++;
                end
            end
            wait_drained();
        end
        repeat (20) @(posedge aclk);
        if (mismatches == 0 && expected_pixels.size() == 0) begin
            $display("** histogram_equalizer: PASSED **");
        end else begin
            $display("** histogram_equalizer: FAILED **");
        end
        $finish;
    end

    initial begin
        #8000000;
        $display("** histogram_equalizer: FAILED **");
        $finish;
    end
endmodule
